// ----- sv/btmx_pkg.sv -----
// Shared constants, types and command codes for the bitwise trie max-xor block.
// Used by btmx_ctrl, btmx_datapath and bitwise_trie_max_xor_limit.
`timescale 1ns / 1ps

package btmx_pkg;

   // Trie geometry
   localparam int KEY_BITS      = 30;
   localparam int NODE_CAPACITY = 8192;
   localparam int VAL_BITS      = 30;

   localparam int IDX_BITS  = $clog2(NODE_CAPACITY);
   localparam int USED_BITS = $clog2(NODE_CAPACITY + 1);
   localparam int LVL_BITS  = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
   localparam int MISS_BITS = $clog2(KEY_BITS + 1);
   localparam int SUM_BITS  = USED_BITS + 1;
   localparam int CMP_BITS  = ((KEY_BITS > VAL_BITS) ? KEY_BITS : VAL_BITS) + 1;

   localparam logic [LVL_BITS-1:0]  LVL_TOP    = LVL_BITS'(KEY_BITS - 1);
   localparam logic [USED_BITS-1:0] USED_RESET = USED_BITS'(1);
   localparam logic [SUM_BITS-1:0]  CAP_SUM    = SUM_BITS'(NODE_CAPACITY);
   localparam logic [CMP_BITS-1:0]  MIN_EMPTY  = '1;

   // One trie node: two child links and the least key below each child
   typedef struct packed {
      logic [1:0][IDX_BITS-1:0] link;
      logic [1:0][KEY_BITS-1:0] cmin;
   } node_entry_type;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_QUERY  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NO_MATCH = 2'd1,
      STATUS_FULL     = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_QUERY,
      CMD_COUNT,
      CMD_INSERT,
      CMD_RESTART,
      CMD_FINISH
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type op;
      status_type status;
   } dp_cmd_type;

   typedef struct packed {
      logic is_query;
      logic lvl_zero;
      logic link_missing;
      logic root_miss;
      logic sure_fit;
      logic overflow;
      logic out_free;
   } dp_stat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_QUERY,
      ST_COUNT,
      ST_FIT,
      ST_INSERT,
      ST_DONE
   } ctl_state_type;

endpackage

// ----- sv/btmx_ctrl.sv -----
// Controller state machine: sequences load, trie walks and result hand-off.
// Depends on btmx_pkg; drives btmx_datapath through dp_cmd_type.
`timescale 1ns / 1ps

module btmx_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  btmx_pkg::dp_stat_type stat,
   output btmx_pkg::dp_cmd_type  cmd
);

   btmx_pkg::ctl_state_type state_ff, state_in;
   btmx_pkg::status_type    status_ff, status_in;

   // Next state and pending result status
   always_comb begin
      state_in  = state_ff;
      status_in = status_ff;
      unique case (state_ff)
         btmx_pkg::ST_IDLE: begin
            if (req_valid) state_in = btmx_pkg::ST_DISPATCH;
         end
         btmx_pkg::ST_DISPATCH: begin
            if (stat.is_query) begin
               if (stat.root_miss) begin
                  state_in  = btmx_pkg::ST_DONE;
                  status_in = btmx_pkg::STATUS_NO_MATCH;
               end else begin
                  state_in = btmx_pkg::ST_QUERY;
               end
            end else if (stat.sure_fit) begin
               state_in = btmx_pkg::ST_INSERT;
            end else begin
               state_in = btmx_pkg::ST_COUNT;
            end
         end
         btmx_pkg::ST_QUERY: begin
            if (stat.lvl_zero) begin
               state_in  = btmx_pkg::ST_DONE;
               status_in = btmx_pkg::STATUS_OK;
            end
         end
         btmx_pkg::ST_COUNT: begin
            if (stat.link_missing || stat.lvl_zero) state_in = btmx_pkg::ST_FIT;
         end
         btmx_pkg::ST_FIT: begin
            if (stat.overflow) begin
               state_in  = btmx_pkg::ST_DONE;
               status_in = btmx_pkg::STATUS_FULL;
            end else begin
               state_in = btmx_pkg::ST_INSERT;
            end
         end
         btmx_pkg::ST_INSERT: begin
            if (stat.lvl_zero) begin
               state_in  = btmx_pkg::ST_DONE;
               status_in = btmx_pkg::STATUS_OK;
            end
         end
         btmx_pkg::ST_DONE: begin
            if (stat.out_free) state_in = btmx_pkg::ST_IDLE;
         end
         default: state_in = btmx_pkg::ST_IDLE;
      endcase
   end

   // Commands to the datapath
   always_comb begin
      cmd.op     = btmx_pkg::CMD_NONE;
      cmd.status = status_ff;
      req_stall  = (state_ff != btmx_pkg::ST_IDLE);
      unique case (state_ff)
         btmx_pkg::ST_IDLE:     if (req_valid) cmd.op = btmx_pkg::CMD_LOAD;
         btmx_pkg::ST_DISPATCH: cmd.op = btmx_pkg::CMD_NONE;
         btmx_pkg::ST_QUERY:    cmd.op = btmx_pkg::CMD_QUERY;
         btmx_pkg::ST_COUNT:    cmd.op = btmx_pkg::CMD_COUNT;
         btmx_pkg::ST_FIT:      if (!stat.overflow) cmd.op = btmx_pkg::CMD_RESTART;
         btmx_pkg::ST_INSERT:   cmd.op = btmx_pkg::CMD_INSERT;
         btmx_pkg::ST_DONE:     if (stat.out_free) cmd.op = btmx_pkg::CMD_FINISH;
         default:               cmd.op = btmx_pkg::CMD_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= btmx_pkg::ST_IDLE;
         status_ff <= btmx_pkg::STATUS_OK;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
      end
   end

endmodule

// ----- sv/btmx_datapath.sv -----
// Datapath: item registers, root node flops, node memory, level walker and result register.
// Depends on btmx_pkg; commanded by btmx_ctrl.
`timescale 1ns / 1ps

module btmx_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  btmx_pkg::dp_cmd_type               cmd,
   output btmx_pkg::dp_stat_type              stat,
   input  logic                               req_operation,
   input  logic [btmx_pkg::VAL_BITS-1:0]      req_key_value,
   input  logic [btmx_pkg::VAL_BITS-1:0]      req_limit,
   input  logic                               rsp_stall,
   output logic                               rsp_valid,
   output logic [btmx_pkg::VAL_BITS-1:0]      rsp_best_xor,
   output logic [1:0]                         rsp_status
);

   // Item and walk registers
   logic [btmx_pkg::KEY_BITS-1:0]  key_ff, key_in;
   logic [btmx_pkg::VAL_BITS-1:0]  lim_ff, lim_in;
   logic                           query_ff, query_in;
   logic [btmx_pkg::LVL_BITS-1:0]  lvl_ff, lvl_in;
   logic [btmx_pkg::IDX_BITS-1:0]  node_ff, node_in;
   logic                           at_root_ff, at_root_in;
   logic                           fresh_ff, fresh_in;
   logic [btmx_pkg::KEY_BITS-1:0]  acc_ff, acc_in;
   logic [btmx_pkg::MISS_BITS-1:0] missing_ff, missing_in;

   // Trie state held in flops
   logic [btmx_pkg::USED_BITS-1:0] used_ff, used_in;
   btmx_pkg::node_entry_type       root_entry_ff, root_entry_in;
   logic [btmx_pkg::CMP_BITS-1:0]  root_min_ff, root_min_in;

   // Result register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [btmx_pkg::VAL_BITS-1:0]  best_ff, best_in;
   btmx_pkg::status_type           status_ff, status_in;

   // Node memory, root entry lives in flops so index zero is never used
   btmx_pkg::node_entry_type node_mem [btmx_pkg::NODE_CAPACITY];
   btmx_pkg::node_entry_type rd_data_ff;
   logic [btmx_pkg::IDX_BITS-1:0] rd_addr;
   logic                          wr_en;

   // Level decode
   btmx_pkg::node_entry_type      cur_entry, new_entry;
   logic                          key_bit, other_bit, other_ok, link_missing, q_dir;
   logic [btmx_pkg::IDX_BITS-1:0] link_same, link_other, q_next, fresh_idx;

   always_comb begin
      if (at_root_ff)    cur_entry = root_entry_ff;
      else if (fresh_ff) cur_entry = '0;
      else               cur_entry = rd_data_ff;

      key_bit      = key_ff[lvl_ff];
      other_bit    = ~key_bit;
      link_same    = cur_entry.link[key_bit];
      link_other   = cur_entry.link[other_bit];
      link_missing = (link_same == '0);
      other_ok     = (link_other != '0) &&
                     (btmx_pkg::CMP_BITS'(cur_entry.cmin[other_bit]) <=
                      btmx_pkg::CMP_BITS'(lim_ff));
      q_dir        = other_ok ? other_bit : key_bit;
      q_next       = cur_entry.link[q_dir];

      // Insert: allocate the missing child or lower its minimum
      fresh_idx = used_ff[btmx_pkg::IDX_BITS-1:0];
      new_entry = cur_entry;
      if (link_missing) begin
         new_entry.link[key_bit] = fresh_idx;
         new_entry.cmin[key_bit] = key_ff;
      end else if (key_ff < cur_entry.cmin[key_bit]) begin
         new_entry.cmin[key_bit] = key_ff;
      end
   end

   // Register updates per command
   always_comb begin
      key_in        = key_ff;
      lim_in        = lim_ff;
      query_in      = query_ff;
      lvl_in        = lvl_ff;
      node_in       = node_ff;
      at_root_in    = at_root_ff;
      fresh_in      = fresh_ff;
      acc_in        = acc_ff;
      missing_in    = missing_ff;
      used_in       = used_ff;
      root_entry_in = root_entry_ff;
      root_min_in   = root_min_ff;
      best_in       = best_ff;
      status_in     = status_ff;
      rd_addr       = link_same;
      wr_en         = 1'b0;

      // drop the result once taken
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (cmd.op)
         btmx_pkg::CMD_LOAD: begin
            key_in     = btmx_pkg::KEY_BITS'(req_key_value);
            lim_in     = req_limit;
            query_in   = (req_operation == btmx_pkg::OP_QUERY);
            lvl_in     = btmx_pkg::LVL_TOP;
            at_root_in = 1'b1;
            fresh_in   = 1'b0;
            acc_in     = '0;
            missing_in = '0;
         end
         btmx_pkg::CMD_RESTART: begin
            lvl_in     = btmx_pkg::LVL_TOP;
            at_root_in = 1'b1;
            fresh_in   = 1'b0;
         end
         btmx_pkg::CMD_QUERY: begin
            if (other_ok) acc_in[lvl_ff] = 1'b1;
            node_in    = q_next;
            rd_addr    = q_next;
            lvl_in     = lvl_ff - btmx_pkg::LVL_BITS'(1);
            at_root_in = 1'b0;
         end
         btmx_pkg::CMD_COUNT: begin
            if (link_missing) begin
               missing_in = btmx_pkg::MISS_BITS'(lvl_ff) + btmx_pkg::MISS_BITS'(1);
            end
            node_in    = link_same;
            rd_addr    = link_same;
            lvl_in     = lvl_ff - btmx_pkg::LVL_BITS'(1);
            at_root_in = 1'b0;
         end
         btmx_pkg::CMD_INSERT: begin
            if (at_root_ff) begin
               root_entry_in = new_entry;
               if (btmx_pkg::CMP_BITS'(key_ff) < root_min_ff) begin
                  root_min_in = btmx_pkg::CMP_BITS'(key_ff);
               end
            end else begin
               wr_en = 1'b1;
            end
            if (link_missing) used_in = used_ff + btmx_pkg::USED_BITS'(1);
            node_in    = new_entry.link[key_bit];
            rd_addr    = new_entry.link[key_bit];
            fresh_in   = link_missing;
            lvl_in     = lvl_ff - btmx_pkg::LVL_BITS'(1);
            at_root_in = 1'b0;
         end
         btmx_pkg::CMD_FINISH: begin
            rsp_valid_in = 1'b1;
            best_in      = btmx_pkg::VAL_BITS'(acc_ff);
            status_in    = cmd.status;
         end
         default: begin
         end
      endcase
   end

   // Status to the controller
   always_comb begin
      stat.is_query     = query_ff;
      stat.lvl_zero     = (lvl_ff == '0);
      stat.link_missing = link_missing;
      stat.root_miss    = (root_min_ff > btmx_pkg::CMP_BITS'(lim_ff));
      stat.sure_fit     = (btmx_pkg::SUM_BITS'(used_ff) + btmx_pkg::SUM_BITS'(btmx_pkg::KEY_BITS))
                          <= btmx_pkg::CAP_SUM;
      stat.overflow     = (btmx_pkg::SUM_BITS'(used_ff) + btmx_pkg::SUM_BITS'(missing_ff))
                          > btmx_pkg::CAP_SUM;
      stat.out_free     = !rsp_valid_ff || !rsp_stall;
   end

   // Node memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) node_mem[node_ff] <= new_entry;
      rd_data_ff <= node_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff       <= btmx_pkg::USED_RESET;
         root_entry_ff <= '0;
         root_min_ff   <= btmx_pkg::MIN_EMPTY;
         rsp_valid_ff  <= 1'b0;
         lvl_ff        <= btmx_pkg::LVL_TOP;
         at_root_ff    <= 1'b1;
         fresh_ff      <= 1'b0;
         missing_ff    <= '0;
         query_ff      <= 1'b0;
      end else begin
         used_ff       <= used_in;
         root_entry_ff <= root_entry_in;
         root_min_ff   <= root_min_in;
         rsp_valid_ff  <= rsp_valid_in;
         lvl_ff        <= lvl_in;
         at_root_ff    <= at_root_in;
         fresh_ff      <= fresh_in;
         missing_ff    <= missing_in;
         query_ff      <= query_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      key_ff    <= key_in;
      lim_ff    <= lim_in;
      node_ff   <= node_in;
      acc_ff    <= acc_in;
      best_ff   <= best_in;
      status_ff <= status_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_best_xor = best_ff;
   assign rsp_status   = status_ff;

endmodule

// ----- sv/bitwise_trie_max_xor_limit.sv -----
// Top level of the bitwise trie max-xor block: controller plus datapath.
// Depends on btmx_pkg, btmx_ctrl and btmx_datapath.
`timescale 1ns / 1ps

// Binary trie over 30-bit keys with inserts and max-xor-under-limit queries.
// One item is worked at a time; each trie level costs one read of the node
// memory, whose registered read data feeds the next level's address. A query
// steps through a load, a dispatch, a walk down all 30 levels and the result,
// or goes from dispatch straight to the result when no stored key is at or
// under the limit. An insert walks the same way while at least 30 nodes
// remain free; closer to the capacity of 8192 nodes it first walks the
// existing path to count the nodes it needs. An insert that does not fit
// answers status 2 and changes nothing. The root is held in flops and every
// other node entry is written when it is allocated, so there is no clearing
// pass after reset. The result register lets a finished item wait on
// rsp_stall while the walk logic is free to load the next one.
module bitwise_trie_max_xor_limit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_operation,
   input  logic [btmx_pkg::VAL_BITS-1:0] req_key_value,
   input  logic [btmx_pkg::VAL_BITS-1:0] req_limit,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [btmx_pkg::VAL_BITS-1:0] rsp_best_xor,
   output logic [1:0]                    rsp_status
);

   btmx_pkg::dp_cmd_type  cmd;
   btmx_pkg::dp_stat_type stat;

   btmx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   btmx_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_operation (req_operation),
      .req_key_value (req_key_value),
      .req_limit     (req_limit),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_best_xor  (rsp_best_xor),
      .rsp_status    (rsp_status)
   );

`ifndef SYNTHESIS
   // An accepted item blocks the input until its result is loaded into the result register
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input not stalled after accepting an item");

   // Results are only loaded when the output register is free
   a_finish_when_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == btmx_pkg::CMD_FINISH) |-> stat.out_free)
      else $error("result loaded over an untaken result");

   // A new result appears only right after a finish command
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.op == btmx_pkg::CMD_FINISH))
      else $error("result valid without a finish command");

   // A dropped insert reports no xor value
   a_full_zero_xor: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == btmx_pkg::STATUS_FULL)) |-> (rsp_best_xor == '0))
      else $error("full status with non-zero xor");
`endif

endmodule
